@@ src/arpc_pkg.sv @@
package arpc_pkg;

  // field widths
  localparam int IP_W        = 32;
  localparam int MAC_W       = 48;
  localparam int AGE_W       = 8;
  localparam int OUT_IDX_W   = 3;
  // entry number width, sized for the largest table (64 entries)
  localparam int ENTRY_IDX_W = 6;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 48;

  localparam logic [AGE_W-1:0] TTL_RESET     = 8'h08;
  localparam logic [MAC_W-1:0] BROADCAST_MAC = {MAC_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_LEARN   = 2'd1,
    CMD_RESOLVE = 2'd2,
    CMD_RSVD    = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_MAC = 1'b0,
    CFG_TTL     = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [IP_W-1:0]  ip_addr;
    logic [IP_W-1:0]  next_hop_ip;
    logic [MAC_W-1:0] mac_addr;
  } in_beat_t;

  typedef struct packed {
    logic                 hit;
    logic [MAC_W-1:0]     dest_mac;
    logic [MAC_W-1:0]     src_mac;
    logic [OUT_IDX_W-1:0] entry_index;
  } out_beat_t;

  // search token that walks the row of entry cells
  typedef struct packed {
    logic                   valid;
    cmd_t                   cmd;
    logic [IP_W-1:0]        key;
    logic [MAC_W-1:0]       mac;
    logic                   found;
    logic [ENTRY_IDX_W-1:0] idx;
    logic [MAC_W-1:0]       hit_mac;
    logic                   free_found;
    logic [ENTRY_IDX_W-1:0] free_idx;
  } token_t;

  // write of a new entry into the first dead slot
  typedef struct packed {
    logic                   en;
    logic [ENTRY_IDX_W-1:0] idx;
    logic [IP_W-1:0]        ip;
    logic [MAC_W-1:0]       mac;
  } fill_t;

endpackage

@@ src/arp_cache_with_aging.sv @@
// ip-to-mac address cache with per-entry aging
// commands: a beat is taken on the rising edge where start is high and
// busy is low; in_data carries cmd, ip_addr, next_hop_ip and mac_addr.
// tick ages every live entry in the accepting cycle and gives no result.
// learn and resolve send a search token down a row of TABLE_ENTRIES entry
// cells, one cell per cycle; busy stays high while the token walks.
// learn refreshes the first live match or fills the first dead slot when
// the token leaves the row; it gives no result. a full table drops it.
// resolve puts one result beat on out_data with out_strobe high for one
// cycle, registered from the token as it leaves the last cell.
// a new learn, resolve or tick is taken only once the token has left the
// cell row; tick and the unused code leave busy low and give no result.
// results cannot be held off; busy is low again in the result cycle.
// config: cfg_we writes own_mac (index 0) or ttl_reload (index 1) at once.
// reset (rst_n low, synchronous) kills every entry, clears own_mac and
// sets ttl_reload to 8.
module arp_cache_with_aging #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  arpc_pkg::in_beat_t                  in_data,
  output logic                                out_strobe,
  output arpc_pkg::out_beat_t                 out_data,
  input  logic                                cfg_we,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [arpc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [arpc_pkg::MAC_W-1:0] own_mac_r, own_mac_nxt;
  logic [arpc_pkg::AGE_W-1:0] ttl_r, ttl_nxt;
  logic                       busy_r, busy_nxt;
  logic                       out_valid_r, out_valid_nxt;
  arpc_pkg::out_beat_t        out_r, out_nxt;

  arpc_pkg::token_t tok [TABLE_ENTRIES+1];
  arpc_pkg::token_t head;
  arpc_pkg::token_t tail;
  arpc_pkg::fill_t  fill;
  logic             accept;
  logic             tick;

  assign accept = start && !busy_r;
  assign tick   = accept && (in_data.cmd == arpc_pkg::CMD_TICK);
  assign tail   = tok[TABLE_ENTRIES];
  assign tok[0] = head;

  // head token built from the accepted beat
  always_comb begin
    head            = '0;
    head.valid      = accept && ((in_data.cmd == arpc_pkg::CMD_LEARN) ||
                                 (in_data.cmd == arpc_pkg::CMD_RESOLVE));
    head.cmd        = in_data.cmd;
    head.key        = ((in_data.cmd == arpc_pkg::CMD_RESOLVE) &&
                       (in_data.next_hop_ip != '0)) ? in_data.next_hop_ip
                                                    : in_data.ip_addr;
    head.mac        = in_data.mac_addr;
  end

  // row of entry cells
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    arpc_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (tok[g]),
      .tick  (tick),
      .ttl   (ttl_r),
      .fill  (fill),
      .tok_o (tok[g+1])
    );
  end

  // new entry into the first dead slot when a learn found no match
  always_comb begin
    fill.en  = tail.valid && (tail.cmd == arpc_pkg::CMD_LEARN) &&
               !tail.found && tail.free_found;
    fill.idx = tail.free_idx;
    fill.ip  = tail.key;
    fill.mac = tail.mac;
  end

  // busy and result beat
  always_comb begin
    busy_nxt = busy_r;
    if (tail.valid) begin
      busy_nxt = 1'b0;
    end else if (head.valid) begin
      busy_nxt = 1'b1;
    end
    out_valid_nxt        = tail.valid && (tail.cmd == arpc_pkg::CMD_RESOLVE);
    out_nxt.hit          = tail.found;
    out_nxt.dest_mac     = tail.found ? tail.hit_mac : arpc_pkg::BROADCAST_MAC;
    out_nxt.src_mac      = own_mac_r;
    out_nxt.entry_index  = tail.found ? tail.idx[arpc_pkg::OUT_IDX_W-1:0] : '0;
  end

  // config registers
  always_comb begin
    own_mac_nxt = own_mac_r;
    ttl_nxt     = ttl_r;
    if (cfg_we) begin
      unique case (arpc_pkg::cfg_idx_t'(cfg_index))
        arpc_pkg::CFG_OWN_MAC: own_mac_nxt = cfg_wdata[arpc_pkg::MAC_W-1:0];
        arpc_pkg::CFG_TTL:     ttl_nxt     = cfg_wdata[arpc_pkg::AGE_W-1:0];
        default:               ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r   <= '0;
      ttl_r       <= arpc_pkg::TTL_RESET;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      own_mac_r   <= own_mac_nxt;
      ttl_r       <= ttl_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign busy       = busy_r;
  assign out_strobe = out_valid_r;
  assign out_data   = out_r;

`ifndef NO_ASSERTIONS
  // no token left in the row while idle
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> !tail.valid)
    else $error("token in cell row while idle");

  // a result beat only follows a resolve leaving the row
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(tail.valid && (tail.cmd == arpc_pkg::CMD_RESOLVE)))
    else $error("result beat without resolve");

  // the block is ready again in the result cycle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy_r)
    else $error("busy during result beat");

  // a miss reports broadcast and entry zero
  a_miss_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.hit) |->
      ((out_r.dest_mac == arpc_pkg::BROADCAST_MAC) && (out_r.entry_index == '0)))
    else $error("bad miss result");
`endif

endmodule

@@ src/arpc_cell.sv @@
module arpc_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  arpc_pkg::token_t             tok_i,
  input  logic                         tick,
  input  logic [arpc_pkg::AGE_W-1:0]   ttl,
  input  arpc_pkg::fill_t              fill,
  output arpc_pkg::token_t             tok_o
);

  localparam logic [arpc_pkg::ENTRY_IDX_W-1:0] MY_IDX = arpc_pkg::ENTRY_IDX_W'(CELL_IDX);

  logic [arpc_pkg::IP_W-1:0]  ip_r,  ip_nxt;
  logic [arpc_pkg::MAC_W-1:0] mac_r, mac_nxt;
  logic [arpc_pkg::AGE_W-1:0] age_r, age_nxt;
  logic                       tok_valid_r;
  arpc_pkg::token_t           tok_r, tok_nxt;

  logic live;
  logic first_hit;
  logic refresh;
  logic fill_me;

  // lookup against this entry
  assign live      = (age_r != '0);
  assign first_hit = tok_i.valid && !tok_i.found && live && (ip_r == tok_i.key);
  assign refresh   = first_hit && (tok_i.cmd == arpc_pkg::CMD_LEARN);
  assign fill_me   = fill.en && (fill.idx == MY_IDX);

  // token update for the next cell
  always_comb begin
    tok_nxt = tok_i;
    if (first_hit) begin
      tok_nxt.found   = 1'b1;
      tok_nxt.idx     = MY_IDX;
      tok_nxt.hit_mac = mac_r;
    end
    if (tok_i.valid && !live && !tok_i.free_found) begin
      tok_nxt.free_found = 1'b1;
      tok_nxt.free_idx   = MY_IDX;
    end
  end

  // entry update: fill, refresh or aging
  always_comb begin
    ip_nxt  = ip_r;
    mac_nxt = mac_r;
    age_nxt = age_r;
    priority if (fill_me) begin
      ip_nxt  = fill.ip;
      mac_nxt = fill.mac;
      age_nxt = ttl;
    end else if (refresh) begin
      mac_nxt = tok_i.mac;
      age_nxt = ttl;
    end else if (tick && live) begin
      age_nxt = age_r - 1'b1;
    end else begin
      age_nxt = age_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ip_r        <= '0;
      age_r       <= '0;
      tok_valid_r <= 1'b0;
    end else begin
      ip_r        <= ip_nxt;
      age_r       <= age_nxt;
      tok_valid_r <= tok_nxt.valid;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    mac_r <= mac_nxt;
    tok_r <= tok_nxt;
  end

  // token out, valid taken from the reset flop
  always_comb begin
    tok_o       = tok_r;
    tok_o.valid = tok_valid_r;
  end

endmodule
